[src/mmnp_pkg.sv]
// mmnp_pkg: shared types, constants and register codes of the min/max normalizer
// used by every module under src except mmnp_ram; depends on nothing
`default_nettype none

package mmnp_pkg;

    // fixed field widths
    localparam int SAMPLE_BITS       = 32;
    localparam int VALUE_BITS        = 16;
    localparam int PEAK_BITS         = 16;
    localparam int COUNT_CFG_BITS    = 17;
    localparam int OUT_MAX_BITS      = 16;
    localparam int STEP_BITS         = $clog2(OUT_MAX_BITS);

    // default store depth as address bits
    localparam int ADDR_BITS_DEFAULT = 16;

    // command queue between front and back
    localparam int Q_DEPTH           = 2;
    localparam int Q_PTR_BITS        = $clog2(Q_DEPTH);
    localparam int Q_LVL_BITS        = $clog2(Q_DEPTH + 1);

    // configuration port
    localparam int APB_ADDR_BITS     = 3;
    localparam int APB_DATA_BITS     = 32;

    localparam logic [COUNT_CFG_BITS-1:0] SAMPLE_COUNT_RESET = 17'h10000;
    localparam logic [OUT_MAX_BITS-1:0]   OUT_MAX_RESET      = 16'd255;

    // item kinds
    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_EMIT = 1'b1;

    typedef enum logic [0:0] {
        REG_SAMPLE_COUNT = 1'b0,
        REG_OUT_MAX      = 1'b1
    } t_reg_idx;

    typedef enum logic [1:0] {
        BK_IDLE = 2'd0,
        BK_MUL  = 2'd1,
        BK_DIV  = 2'd2
    } t_bk_state;

    typedef struct packed {
        logic                          kind;
        logic signed [SAMPLE_BITS-1:0] sample;
    } t_in_item;

    typedef struct packed {
        logic [VALUE_BITS-1:0] value;
        logic [PEAK_BITS-1:0]  peak_index;
        logic                  last;
        logic                  error;
    } t_out_item;

    // one emit as handed from front to back, with its frame snapshot
    typedef struct packed {
        logic                          err;
        logic                          last;
        logic [PEAK_BITS-1:0]          peak;
        logic signed [SAMPLE_BITS-1:0] x;
        logic signed [SAMPLE_BITS-1:0] frame_lo;
        logic [SAMPLE_BITS:0]          span;
    } t_job;

    typedef struct packed {
        logic [Q_LVL_BITS-1:0] level;
        logic                  empty;
    } t_q_stat;

endpackage

`default_nettype wire

[src/mmnp_ram.sv]
// mmnp_ram: generic single-write, single-read memory with registered read data
// no dependencies
`default_nettype none

module mmnp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 65536
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

[src/mmnp_front.sv]
// mmnp_front: accepts items, stores samples, tracks min/max/peak, classifies emits
// depends on mmnp_pkg; drives the sample store and pushes jobs into mmnp_queue
`default_nettype none

module mmnp_front #(
    parameter int ADDR_BITS = mmnp_pkg::ADDR_BITS_DEFAULT
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_start,
    input  wire mmnp_pkg::t_in_item                    i_item,
    output logic                                       o_busy,
    input  wire logic [mmnp_pkg::COUNT_CFG_BITS-1:0]   i_sample_count,
    input  wire mmnp_pkg::t_q_stat                     i_q_stat,
    output logic                                       o_push,
    output mmnp_pkg::t_job                             o_job,
    output logic                                       o_ram_we,
    output logic [ADDR_BITS-1:0]                       o_ram_waddr,
    output logic [mmnp_pkg::SAMPLE_BITS-1:0]           o_ram_wdata,
    output logic                                       o_ram_re,
    output logic [ADDR_BITS-1:0]                       o_ram_raddr,
    input  wire logic [mmnp_pkg::SAMPLE_BITS-1:0]      i_ram_rdata
);

    localparam int SB = mmnp_pkg::SAMPLE_BITS;
    localparam int CW = ADDR_BITS + 1;
    localparam int MW = (ADDR_BITS + 1 > mmnp_pkg::COUNT_CFG_BITS) ?
                        ADDR_BITS + 1 : mmnp_pkg::COUNT_CFG_BITS;
    localparam logic [MW-1:0] FRAME_MAX = MW'(2 ** ADDR_BITS);

    logic [CW-1:0]          r_wr_cnt, n_wr_cnt;
    logic [CW-1:0]          r_rd_cnt, n_rd_cnt;
    logic signed [SB-1:0]   r_lo, n_lo;
    logic signed [SB-1:0]   r_hi, n_hi;
    logic [ADDR_BITS-1:0]   r_peak, n_peak;
    logic                   r_pend, n_pend;
    mmnp_pkg::t_job         r_pend_job, n_pend_job;

    logic [MW-1:0]                   sc_ext;
    logic [MW-1:0]                   frame_len;
    logic                            loaded;
    logic                            is_last;
    logic                            accept;
    logic [mmnp_pkg::Q_LVL_BITS:0]   in_flight;
    logic signed [SB-1:0]            smp;

    // frame length clamped to 1 .. store depth
    always_comb begin
        sc_ext = MW'(i_sample_count);
        if (sc_ext == '0) begin
            frame_len = MW'(1);
        end else if (sc_ext > FRAME_MAX) begin
            frame_len = FRAME_MAX;
        end else begin
            frame_len = sc_ext;
        end
    end

    assign loaded    = MW'(r_wr_cnt) >= frame_len;
    assign is_last   = (MW'(r_rd_cnt) + MW'(1)) >= frame_len;
    assign in_flight = {1'b0, i_q_stat.level} + {{mmnp_pkg::Q_LVL_BITS{1'b0}}, r_pend};
    assign o_busy    = in_flight >= (mmnp_pkg::Q_LVL_BITS + 1)'(mmnp_pkg::Q_DEPTH);
    assign accept    = i_start && !o_busy;
    assign smp       = i_item.sample;

    always_comb begin
        n_wr_cnt   = r_wr_cnt;
        n_rd_cnt   = r_rd_cnt;
        n_lo       = r_lo;
        n_hi       = r_hi;
        n_peak     = r_peak;
        n_pend     = 1'b0;
        n_pend_job = r_pend_job;
        o_ram_we   = 1'b0;
        o_ram_re   = 1'b0;
        if (accept) begin
            if (i_item.kind == mmnp_pkg::KIND_LOAD) begin
                // a load into a full frame is dropped
                if (!loaded) begin
                    o_ram_we = 1'b1;
                    n_wr_cnt = r_wr_cnt + CW'(1);
                    priority if (r_wr_cnt == '0) begin
                        n_lo   = smp;
                        n_hi   = smp;
                        n_peak = '0;
                    end else if (smp > r_hi) begin
                        n_hi   = smp;
                        n_peak = r_wr_cnt[ADDR_BITS-1:0];
                    end else if (smp < r_lo) begin
                        n_lo = smp;
                    end else begin
                        n_lo = r_lo;
                    end
                end
            end else begin
                n_pend              = 1'b1;
                n_pend_job.x        = '0;
                n_pend_job.frame_lo = r_lo;
                n_pend_job.span     = {r_hi[SB-1], r_hi} - {r_lo[SB-1], r_lo};
                if (!loaded) begin
                    n_pend_job.err  = 1'b1;
                    n_pend_job.last = 1'b0;
                    n_pend_job.peak = '0;
                end else begin
                    o_ram_re        = 1'b1;
                    n_pend_job.err  = 1'b0;
                    n_pend_job.last = is_last;
                    n_pend_job.peak = mmnp_pkg::PEAK_BITS'(r_peak);
                    if (is_last) begin
                        n_wr_cnt = '0;
                        n_rd_cnt = '0;
                    end else begin
                        n_rd_cnt = r_rd_cnt + CW'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_cnt <= '0;
            r_rd_cnt <= '0;
            r_lo     <= '0;
            r_hi     <= '0;
            r_peak   <= '0;
            r_pend   <= 1'b0;
        end else begin
            r_wr_cnt <= n_wr_cnt;
            r_rd_cnt <= n_rd_cnt;
            r_lo     <= n_lo;
            r_hi     <= n_hi;
            r_peak   <= n_peak;
            r_pend   <= n_pend;
        end
        r_pend_job <= n_pend_job;
    end

    assign o_ram_waddr = r_wr_cnt[ADDR_BITS-1:0];
    assign o_ram_wdata = smp;
    assign o_ram_raddr = r_rd_cnt[ADDR_BITS-1:0];

    // sample read from the store lands in the cycle after the emit, with the pending job
    assign o_push = r_pend;
    always_comb begin
        o_job   = r_pend_job;
        o_job.x = $signed(i_ram_rdata);
    end

`ifndef SYNTH
    a_wr_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        MW'(r_wr_cnt) <= FRAME_MAX)
        else $error("write count past store depth");

    a_hi_ge_lo: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_wr_cnt != '0) |-> (r_hi >= r_lo))
        else $error("frame maximum below minimum");
`endif

endmodule

`default_nettype wire

[src/mmnp_queue.sv]
// mmnp_queue: short fifo of emit jobs between front and back
// depends on mmnp_pkg
`default_nettype none

module mmnp_queue (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_push,
    input  wire mmnp_pkg::t_job     i_job,
    input  wire logic               i_pop,
    output mmnp_pkg::t_job          o_job,
    output mmnp_pkg::t_q_stat       o_stat
);

    mmnp_pkg::t_job                      r_slot [mmnp_pkg::Q_DEPTH];
    logic [mmnp_pkg::Q_PTR_BITS-1:0]     r_wp;
    logic [mmnp_pkg::Q_PTR_BITS-1:0]     r_rp;
    logic [mmnp_pkg::Q_LVL_BITS-1:0]     r_level;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_level <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + mmnp_pkg::Q_PTR_BITS'(1);
            end
            if (i_pop) begin
                r_rp <= r_rp + mmnp_pkg::Q_PTR_BITS'(1);
            end
            unique case ({i_push, i_pop})
                2'b10:   r_level <= r_level + mmnp_pkg::Q_LVL_BITS'(1);
                2'b01:   r_level <= r_level - mmnp_pkg::Q_LVL_BITS'(1);
                default: r_level <= r_level;
            endcase
        end
        if (i_push) begin
            r_slot[r_wp] <= i_job;
        end
    end

    assign o_job        = r_slot[r_rp];
    assign o_stat.level = r_level;
    assign o_stat.empty = (r_level == '0);

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && !i_pop && (r_level == mmnp_pkg::Q_LVL_BITS'(mmnp_pkg::Q_DEPTH))))
        else $error("job queue overflow");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && (r_level == '0)))
        else $error("job queue underflow");
`endif

endmodule

`default_nettype wire

[src/mmnp_back.sv]
// mmnp_back: scales one job at a time with a shift-add multiply and restoring divide
// depends on mmnp_pkg; pops jobs from mmnp_queue, drives the result registers
`default_nettype none

module mmnp_back (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire mmnp_pkg::t_job                       i_job,
    input  wire mmnp_pkg::t_q_stat                    i_q_stat,
    output logic                                      o_pop,
    input  wire logic [mmnp_pkg::OUT_MAX_BITS-1:0]    i_out_max,
    output logic                                      o_done,
    output mmnp_pkg::t_out_item                       o_result
);

    localparam int SB = mmnp_pkg::SAMPLE_BITS;
    localparam int PW = SB + 1 + mmnp_pkg::OUT_MAX_BITS;
    localparam int VB = mmnp_pkg::VALUE_BITS;
    localparam logic [mmnp_pkg::STEP_BITS-1:0] STEP_TOP = '1;

    mmnp_pkg::t_bk_state              r_state, n_state;
    logic [mmnp_pkg::STEP_BITS-1:0]   r_cnt, n_cnt;
    logic [PW-1:0]                    r_acc, n_acc;
    logic [PW-1:0]                    r_dvs, n_dvs;
    logic [SB:0]                      r_diff, n_diff;
    logic [VB-1:0]                    r_q, n_q;
    logic [mmnp_pkg::PEAK_BITS-1:0]   r_peak, n_peak;
    logic                             r_last, n_last;
    logic                             r_done, n_done;
    mmnp_pkg::t_out_item              r_res, n_res;

    logic [SB:0]   diff_full;
    logic [PW:0]   trial;
    logic          q_bit;

    assign diff_full = {i_job.x[SB-1], i_job.x} - {i_job.frame_lo[SB-1], i_job.frame_lo};
    assign trial     = {1'b0, r_acc} - {1'b0, r_dvs};
    assign q_bit     = !trial[PW];

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_acc   = r_acc;
        n_dvs   = r_dvs;
        n_diff  = r_diff;
        n_q     = r_q;
        n_peak  = r_peak;
        n_last  = r_last;
        n_done  = 1'b0;
        n_res   = r_res;
        o_pop   = 1'b0;
        unique case (r_state)
            mmnp_pkg::BK_IDLE: begin
                if (!i_q_stat.empty) begin
                    o_pop  = 1'b1;
                    n_peak = i_job.peak;
                    n_last = i_job.last;
                    if (i_job.err) begin
                        n_done           = 1'b1;
                        n_res.value      = '0;
                        n_res.peak_index = '0;
                        n_res.last       = 1'b0;
                        n_res.error      = 1'b1;
                    end else if (i_job.span == '0) begin
                        // flat frame
                        n_done           = 1'b1;
                        n_res.value      = '0;
                        n_res.peak_index = i_job.peak;
                        n_res.last       = i_job.last;
                        n_res.error      = 1'b0;
                    end else begin
                        if (i_job.x <= i_job.frame_lo) begin
                            n_diff = '0;
                        end else if (diff_full > i_job.span) begin
                            n_diff = i_job.span;
                        end else begin
                            n_diff = diff_full;
                        end
                        n_acc   = '0;
                        n_cnt   = STEP_TOP;
                        n_dvs   = PW'(i_job.span) << (mmnp_pkg::OUT_MAX_BITS - 1);
                        n_state = mmnp_pkg::BK_MUL;
                    end
                end
            end
            mmnp_pkg::BK_MUL: begin
                // out_max bits from the top down
                n_acc = {r_acc[PW-2:0], 1'b0} + (i_out_max[r_cnt] ? PW'(r_diff) : '0);
                n_cnt = r_cnt - mmnp_pkg::STEP_BITS'(1);
                if (r_cnt == '0) begin
                    n_cnt   = STEP_TOP;
                    n_q     = '0;
                    n_state = mmnp_pkg::BK_DIV;
                end
            end
            mmnp_pkg::BK_DIV: begin
                if (q_bit) begin
                    n_acc = trial[PW-1:0];
                end
                n_q   = {r_q[VB-2:0], q_bit};
                n_dvs = r_dvs >> 1;
                n_cnt = r_cnt - mmnp_pkg::STEP_BITS'(1);
                if (r_cnt == '0) begin
                    n_done           = 1'b1;
                    n_res.value      = {r_q[VB-2:0], q_bit};
                    n_res.peak_index = r_peak;
                    n_res.last       = r_last;
                    n_res.error      = 1'b0;
                    n_state          = mmnp_pkg::BK_IDLE;
                end
            end
            default: begin
                n_state = mmnp_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mmnp_pkg::BK_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
        r_cnt  <= n_cnt;
        r_acc  <= n_acc;
        r_dvs  <= n_dvs;
        r_diff <= n_diff;
        r_q    <= n_q;
        r_peak <= n_peak;
        r_last <= n_last;
        r_res  <= n_res;
    end

    assign o_done   = r_done;
    assign o_result = r_res;

`ifndef SYNTH
    a_err_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.error) |-> ((o_result.value == '0) && !o_result.last))
        else $error("error result carries data");

    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> ((r_state != mmnp_pkg::BK_IDLE) || r_done))
        else $error("popped job neither started nor finished");
`endif

endmodule

`default_nettype wire

[src/min_max_normalize_with_peak.sv]
// min_max_normalize_with_peak: top level, configuration registers and the wiring
// of mmnp_front, mmnp_ram, mmnp_queue and mmnp_back; depends on mmnp_pkg
`default_nettype none

// channel      | ports                                  | transfer when
// -------------+----------------------------------------+----------------------------------
// item in      | start, busy, i_item                    | start high and busy low
// result out   | o_done, o_result                       | o_done high (one cycle, no stall)
// config       | psel, penable, pwrite, paddr, pwdata,  | psel, penable, pwrite, pready high
//              | prdata, pready                         |
//
// loads stream one per cycle while the job queue has room
// an emit that scales runs in the back end through a pop, 16 shift-add multiply
// steps and 16 restoring divide steps
// an early emit or a flat frame gives its result without multiply or divide steps
// busy rises when the two-entry job queue plus the pending store read is full
// reset is synchronous, active low; the sample store is not cleared and needs no sweep
// results cannot be held off by the receiver, so the back end never waits on output

module min_max_normalize_with_peak #(
    parameter int ADDR_BITS = mmnp_pkg::ADDR_BITS_DEFAULT
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    // item channel
    input  wire logic                                 start,
    output logic                                      busy,
    input  wire mmnp_pkg::t_in_item                   i_item,
    // result channel
    output logic                                      o_done,
    output mmnp_pkg::t_out_item                       o_result,
    // configuration port
    input  wire logic                                 psel,
    input  wire logic                                 penable,
    input  wire logic                                 pwrite,
    input  wire logic [mmnp_pkg::APB_ADDR_BITS-1:0]   paddr,
    input  wire logic [mmnp_pkg::APB_DATA_BITS-1:0]   pwdata,
    output logic [mmnp_pkg::APB_DATA_BITS-1:0]        prdata,
    output logic                                      pready
);

    localparam int SB = mmnp_pkg::SAMPLE_BITS;

    // configuration registers
    logic [mmnp_pkg::COUNT_CFG_BITS-1:0] r_sample_count;
    logic [mmnp_pkg::OUT_MAX_BITS-1:0]   r_out_max;
    logic                                cfg_wr;
    mmnp_pkg::t_reg_idx                  reg_sel;

    // front to store
    logic                  ram_we;
    logic [ADDR_BITS-1:0]  ram_waddr;
    logic [SB-1:0]         ram_wdata;
    logic                  ram_re;
    logic [ADDR_BITS-1:0]  ram_raddr;
    logic [SB-1:0]         ram_rdata;

    // front to queue to back
    logic                  q_push;
    mmnp_pkg::t_job        q_in_job;
    logic                  q_pop;
    mmnp_pkg::t_job        q_head;
    mmnp_pkg::t_q_stat     q_stat;

    // apb: no wait states, write lands on the access cycle
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_sel = mmnp_pkg::t_reg_idx'(paddr[2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_count <= mmnp_pkg::SAMPLE_COUNT_RESET;
            r_out_max      <= mmnp_pkg::OUT_MAX_RESET;
        end else if (cfg_wr) begin
            unique case (reg_sel)
                mmnp_pkg::REG_SAMPLE_COUNT:
                    r_sample_count <= pwdata[mmnp_pkg::COUNT_CFG_BITS-1:0];
                mmnp_pkg::REG_OUT_MAX:
                    r_out_max <= pwdata[mmnp_pkg::OUT_MAX_BITS-1:0];
            endcase
        end
    end

    // read back is combinational from the address
    always_comb begin
        unique case (reg_sel)
            mmnp_pkg::REG_SAMPLE_COUNT: prdata = mmnp_pkg::APB_DATA_BITS'(r_sample_count);
            mmnp_pkg::REG_OUT_MAX:      prdata = mmnp_pkg::APB_DATA_BITS'(r_out_max);
        endcase
    end

    // front end: loads, min/max/peak tracking, emit classification
    mmnp_front #(
        .ADDR_BITS (ADDR_BITS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_item         (i_item),
        .o_busy         (busy),
        .i_sample_count (r_sample_count),
        .i_q_stat       (q_stat),
        .o_push         (q_push),
        .o_job          (q_in_job),
        .o_ram_we       (ram_we),
        .o_ram_waddr    (ram_waddr),
        .o_ram_wdata    (ram_wdata),
        .o_ram_re       (ram_re),
        .o_ram_raddr    (ram_raddr),
        .i_ram_rdata    (ram_rdata)
    );

    // frame sample store
    mmnp_ram #(
        .WIDTH (SB),
        .DEPTH (2 ** ADDR_BITS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // jobs carry their own min/span snapshot, so the next frame can load meanwhile
    mmnp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (q_in_job),
        .i_pop   (q_pop),
        .o_job   (q_head),
        .o_stat  (q_stat)
    );

    // back end: scaling and result registers
    mmnp_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_job     (q_head),
        .i_q_stat  (q_stat),
        .o_pop     (q_pop),
        .i_out_max (r_out_max),
        .o_done    (o_done),
        .o_result  (o_result)
    );

endmodule

`default_nettype wire

[sim/min_max_normalize_with_peak_tb.sv]
// min_max_normalize_with_peak_tb: self-checking bench for the min/max normalizer with peak index
// directed table then random frames, scored against an in-bench model; depends on mmnp_pkg
`default_nettype none

module min_max_normalize_with_peak_tb;

    // run shape
    localparam int ITEM_TARGET   = 1650;  // stimulus stops once this many items counted
    localparam int QUIET_FROM    = 1400;  // no sender gaps past this point
    localparam int SETTLE_CYCLES = 48;    // extra wait once every owed pixel is back
    localparam int STALL_LIMIT   = 2000;  // cycles without any transfer before giving up
    localparam int STORE_DEPTH   = 1 << mmnp_pkg::ADDR_BITS_DEFAULT;

    // directed table
    typedef enum logic [1:0] {
        ROW_LOAD,
        ROW_EMIT,
        ROW_SET_COUNT,
        ROW_SET_OUT_MAX
    } t_row_op;

    typedef struct packed {
        t_row_op             op;
        logic [31:0]         data;
        logic                typed;   // want holds a hand-written result
        mmnp_pkg::t_out_item want;
    } t_row;

    localparam mmnp_pkg::t_out_item NONE      = '0;
    localparam mmnp_pkg::t_out_item EARLY     =
        '{value: 16'd0, peak_index: 16'd0, last: 1'b0, error: 1'b1};
    localparam mmnp_pkg::t_out_item ZERO_LAST =
        '{value: 16'd0, peak_index: 16'd0, last: 1'b1, error: 1'b0};
    localparam mmnp_pkg::t_out_item ZERO_MID  =
        '{value: 16'd0, peak_index: 16'd0, last: 1'b0, error: 1'b0};

    localparam int DIRECTED_LEN = 36;
    localparam t_row DIRECTED_ROWS [DIRECTED_LEN] = '{
        // reset length is 65536, so nothing can be read out yet
        '{ROW_EMIT,        32'h0000_0000, 1'b1, EARLY},
        '{ROW_LOAD,        32'h7FFF_FFFF, 1'b0, NONE},
        '{ROW_EMIT,        32'h0000_0000, 1'b1, EARLY},
        // widest length register value clamps to the store depth
        '{ROW_SET_COUNT,   32'h0001_FFFF, 1'b0, NONE},
        '{ROW_EMIT,        32'h0000_0000, 1'b1, EARLY},
        // zero length acts as one, so the single loaded sample completes the frame
        '{ROW_SET_COUNT,   32'h0000_0000, 1'b0, NONE},
        '{ROW_EMIT,        32'h0000_0000, 1'b1, ZERO_LAST},
        '{ROW_LOAD,        32'h8000_0000, 1'b0, NONE},
        // full and undrained: this load is dropped
        '{ROW_LOAD,        32'h0000_0005, 1'b0, NONE},
        '{ROW_EMIT,        32'h0000_0000, 1'b1, ZERO_LAST},
        // full-scale extremes, tie on the maximum keeps the first peak
        '{ROW_SET_COUNT,   32'h0000_0003, 1'b0, NONE},
        '{ROW_SET_OUT_MAX, 32'h0000_FFFF, 1'b0, NONE},
        '{ROW_LOAD,        32'h8000_0000, 1'b0, NONE},
        '{ROW_LOAD,        32'h7FFF_FFFF, 1'b0, NONE},
        '{ROW_LOAD,        32'h7FFF_FFFF, 1'b0, NONE},
        '{ROW_EMIT,        32'h0000_0000, 1'b1,
            '{value: 16'd0,     peak_index: 16'd1, last: 1'b0, error: 1'b0}},
        '{ROW_EMIT,        32'h0000_0000, 1'b1,
            '{value: 16'hFFFF, peak_index: 16'd1, last: 1'b0, error: 1'b0}},
        '{ROW_EMIT,        32'h0000_0000, 1'b1,
            '{value: 16'hFFFF, peak_index: 16'd1, last: 1'b1, error: 1'b0}},
        // zero full scale gives zero everywhere
        '{ROW_SET_OUT_MAX, 32'h0000_0000, 1'b0, NONE},
        '{ROW_SET_COUNT,   32'h0000_0002, 1'b0, NONE},
        '{ROW_LOAD,        32'h0000_0007, 1'b0, NONE},
        '{ROW_LOAD,        32'hFFFF_FFFD, 1'b0, NONE},
        '{ROW_EMIT,        32'h0000_0000, 1'b1, ZERO_MID},
        '{ROW_EMIT,        32'h0000_0000, 1'b1, ZERO_LAST},
        // q16.16 values, new minimum late in the frame
        '{ROW_SET_OUT_MAX, 32'h0000_03E8, 1'b0, NONE},
        '{ROW_SET_COUNT,   32'h0000_0005, 1'b0, NONE},
        '{ROW_LOAD,        32'hFFFF_0000, 1'b0, NONE},
        '{ROW_LOAD,        32'h0001_0000, 1'b0, NONE},
        '{ROW_LOAD,        32'h0001_0000, 1'b0, NONE},
        '{ROW_LOAD,        32'hFFFE_0000, 1'b0, NONE},
        '{ROW_LOAD,        32'h0000_8000, 1'b0, NONE},
        '{ROW_EMIT,        32'h0000_0000, 1'b0, NONE},
        '{ROW_EMIT,        32'h0000_0000, 1'b0, NONE},
        '{ROW_EMIT,        32'h0000_0000, 1'b0, NONE},
        // shrink the length below the read position: next emit ends the frame
        '{ROW_SET_COUNT,   32'h0000_0002, 1'b0, NONE},
        '{ROW_EMIT,        32'h0000_0000, 1'b0, NONE}
    };

    // dut signals, every input known from time zero
    logic                               i_clk   = 1'b0;
    logic                               i_rst_n = 1'b0;
    logic                               start   = 1'b0;
    logic                               busy;
    mmnp_pkg::t_in_item                 i_item  = '0;
    logic                               o_done;
    mmnp_pkg::t_out_item                o_result;
    logic                               psel    = 1'b0;
    logic                               penable = 1'b0;
    logic                               pwrite  = 1'b0;
    logic [mmnp_pkg::APB_ADDR_BITS-1:0] paddr   = '0;
    logic [mmnp_pkg::APB_DATA_BITS-1:0] pwdata  = '0;
    logic [mmnp_pkg::APB_DATA_BITS-1:0] prdata;
    logic                               pready;

    // bench model of the block: frame store, counters, running min/max, registers
    int                                  stored_samples [STORE_DEPTH];
    int                                  load_count;
    int                                  emit_count;
    int                                  frame_lo;
    int                                  frame_hi;
    int                                  peak_at;
    logic [mmnp_pkg::COUNT_CFG_BITS-1:0] reg_sample_count;
    logic [mmnp_pkg::OUT_MAX_BITS-1:0]   reg_out_max;

    // normalized pixels still owed by the dut, oldest first
    mmnp_pkg::t_out_item pixels_due [$];

    int fail_count   = 0;
    int items_done   = 0;
    int stall_cycles = 0;

    min_max_normalize_with_peak i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .o_done   (o_done),
        .o_result (o_result),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    task automatic flag(input string what, input logic [63:0] want, input logic [63:0] got);
        $display("%0t %s mismatch: expected %0h, actual %0h", $time, what, want, got);
        fail_count++;
    endtask

    // length register clamped to 1 .. store depth
    function automatic int frame_length();
        if (reg_sample_count == '0) return 1;
        if (reg_sample_count > STORE_DEPTH) return STORE_DEPTH;
        return int'(reg_sample_count);
    endfunction

    // one accepted item through the model; returns 1 when it yields a pixel
    function automatic bit normalize_step(input mmnp_pkg::t_in_item it,
                                          output mmnp_pkg::t_out_item res);
        int     n;
        int     x;
        longint span;
        longint diff;
        n   = frame_length();
        res = '0;
        if (it.kind == mmnp_pkg::KIND_LOAD) begin
            // full and not yet drained: dropped
            if (load_count >= n) return 1'b0;
            x = it.sample;
            stored_samples[load_count] = x;
            if (load_count == 0) begin
                frame_lo = x;
                frame_hi = x;
                peak_at  = 0;
            end else if (x > frame_hi) begin
                frame_hi = x;
                peak_at  = load_count;
            end else if (x < frame_lo) begin
                frame_lo = x;
            end
            load_count++;
            return 1'b0;
        end
        // emit before the frame is complete: error, state untouched
        if (load_count < n) begin
            res.error = 1'b1;
            return 1'b1;
        end
        x              = stored_samples[emit_count];
        res.peak_index = 16'(peak_at);
        res.last       = (emit_count + 1 >= n);
        // flat frame leaves value at zero
        if (frame_hi > frame_lo) begin
            span = longint'(frame_hi) - longint'(frame_lo);
            diff = (x > frame_lo) ? longint'(x) - longint'(frame_lo) : 64'sd0;
            if (diff > span) diff = span;
            res.value = 16'((diff * longint'(reg_out_max)) / span);
        end
        if (res.last) begin
            load_count = 0;
            emit_count = 0;
        end else begin
            emit_count++;
        end
        return 1'b1;
    endfunction

    function automatic mmnp_pkg::t_in_item make_item(input logic kind, input int sample);
        mmnp_pkg::t_in_item it;
        it.kind   = kind;
        it.sample = sample;
        return it;
    endfunction

    // sample flavors per frame: wide random, narrow cluster, flat, extremes
    function automatic int pick_sample(input int style, input int base);
        case (style)
            0, 1: return $urandom;
            2, 3: return base + $urandom_range(0, 15);
            4:    return base;
            default: begin
                case ($urandom_range(0, 4))
                    0:       return 32'h8000_0000;
                    1:       return 32'h7FFF_FFFF;
                    2:       return 0;
                    3:       return -1;
                    default: return $urandom;
                endcase
            end
        endcase
    endfunction

    // one item transfer, with an occasional sender gap in front of it
    task automatic drive_item(input mmnp_pkg::t_in_item it, input bit typed,
                              input mmnp_pkg::t_out_item want);
        mmnp_pkg::t_out_item res;
        // dropped loads do not count toward the item target
        if (it.kind == mmnp_pkg::KIND_EMIT || load_count < frame_length()) items_done++;
        if (items_done < QUIET_FROM && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        start  <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (busy !== 1'b0);
        // transfer happened at this edge
        if (normalize_step(it, res)) pixels_due.push_back(typed ? want : res);
    endtask

    // stop sending, let every owed pixel arrive, then let the back end go quiet
    task automatic wait_idle();
        start <= 1'b0;
        while (pixels_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // register write followed by a read back of the same register
    task automatic cfg_write(input mmnp_pkg::t_reg_idx sel, input logic [31:0] data);
        logic [31:0] readback;
        logic [31:0] want;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        // register takes the value at this edge
        if (sel == mmnp_pkg::REG_SAMPLE_COUNT) begin
            reg_sample_count = data[mmnp_pkg::COUNT_CFG_BITS-1:0];
        end else begin
            reg_out_max = data[mmnp_pkg::OUT_MAX_BITS-1:0];
        end
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        readback = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        want = (sel == mmnp_pkg::REG_SAMPLE_COUNT) ? 32'(reg_sample_count)
                                                   : 32'(reg_out_max);
        if (readback !== want) flag("register read back", want, readback);
    endtask

    // result side: the receiver cannot stall, every strobe is a transfer
    always @(posedge i_clk) begin : score_pixels
        mmnp_pkg::t_out_item want;
        if (i_rst_n && o_done === 1'b1) begin
            if (pixels_due.size() == 0) begin
                flag("unexpected result", '0, o_result);
            end else begin
                want = pixels_due.pop_front();
                if (o_result.value !== want.value) flag("value", want.value, o_result.value);
                if (o_result.peak_index !== want.peak_index) begin
                    flag("peak_index", want.peak_index, o_result.peak_index);
                end
                if (o_result.last !== want.last) flag("last", want.last, o_result.last);
                if (o_result.error !== want.error) flag("error", want.error, o_result.error);
            end
        end
    end

    // watchdog: any item, result or register transfer restarts the count
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && busy === 1'b0) || o_done === 1'b1 || (psel && penable)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("%0t watchdog: no transfer for %0d cycles", $time, stall_cycles);
                $display("status: fail");
                $finish;
            end
        end
    end

    initial begin : stimulus
        t_row row;
        int   n;
        int   need;
        int   emits;
        int   len;
        int   shape;
        int   style;
        int   base;
        int   pick;
        bit   held_off;

        // model state after reset
        load_count       = 0;
        emit_count       = 0;
        frame_lo         = 0;
        frame_hi         = 0;
        peak_at          = 0;
        reg_sample_count = mmnp_pkg::SAMPLE_COUNT_RESET;
        reg_out_max      = mmnp_pkg::OUT_MAX_RESET;
        held_off         = 1'b0;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed table
        for (int r = 0; r < DIRECTED_LEN; r++) begin
            row = DIRECTED_ROWS[r];
            case (row.op)
                ROW_LOAD: begin
                    drive_item(make_item(mmnp_pkg::KIND_LOAD, row.data), row.typed, row.want);
                end
                ROW_EMIT: begin
                    drive_item(make_item(mmnp_pkg::KIND_EMIT, $urandom), row.typed, row.want);
                end
                ROW_SET_COUNT: begin
                    wait_idle();
                    cfg_write(mmnp_pkg::REG_SAMPLE_COUNT, row.data);
                end
                default: begin
                    wait_idle();
                    cfg_write(mmnp_pkg::REG_OUT_MAX, row.data);
                end
            endcase
        end

        // random frames, registers changed only with the dut quiet
        while (items_done < ITEM_TARGET) begin
            wait_idle();
            if ($urandom_range(0, 3) != 0) begin
                pick = $urandom_range(0, 99);
                if (pick < 70)      n = $urandom_range(1, 8);
                else if (pick < 88) n = $urandom_range(9, 24);
                else if (pick < 93) n = $urandom_range(25, 60);
                else if (pick < 96) n = 0;
                else if (pick < 98) n = $urandom_range(STORE_DEPTH, 2 * STORE_DEPTH - 1);
                else                n = STORE_DEPTH;
                cfg_write(mmnp_pkg::REG_SAMPLE_COUNT, n);
            end
            if ($urandom_range(0, 1) == 0) begin
                pick = $urandom_range(0, 99);
                if (pick < 15)      cfg_write(mmnp_pkg::REG_OUT_MAX, 32'h0000_FFFF);
                else if (pick < 25) cfg_write(mmnp_pkg::REG_OUT_MAX, 32'd1);
                else if (pick < 30) cfg_write(mmnp_pkg::REG_OUT_MAX, 32'd0);
                else                cfg_write(mmnp_pkg::REG_OUT_MAX, $urandom_range(2, 65534));
            end

            style = $urandom_range(0, 5);
            base  = $urandom;
            shape = $urandom_range(0, 99);
            n     = frame_length();
            need  = (load_count < n) ? n - load_count : 0;

            if (shape < 75 && need <= 64) begin
                // well-formed: fill the frame, then drain it completely
                repeat (need) begin
                    drive_item(make_item(mmnp_pkg::KIND_LOAD, pick_sample(style, base)),
                               1'b0, NONE);
                end
                emits = (emit_count < n) ? n - emit_count : 1;
                for (int k = 0; k < emits; k++) begin
                    // hold off mid-drain until every owed pixel is back
                    if (k == emits / 2 && emits >= 2 &&
                        (!held_off || $urandom_range(0, 9) == 0)) begin
                        wait_idle();
                        held_off = 1'b1;
                    end
                    drive_item(make_item(mmnp_pkg::KIND_EMIT, $urandom), 1'b0, NONE);
                end
            end else begin
                // noise: loads and emits mixed, early emits and partial frames
                len = $urandom_range(1, 2 * ((n < 24) ? n : 24) + 2);
                repeat (len) begin
                    if ($urandom_range(0, 99) < 55) begin
                        drive_item(make_item(mmnp_pkg::KIND_LOAD, pick_sample(style, base)),
                                   1'b0, NONE);
                    end else begin
                        drive_item(make_item(mmnp_pkg::KIND_EMIT, $urandom), 1'b0, NONE);
                    end
                end
            end
        end

        wait_idle();
        if (fail_count == 0 && pixels_due.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

`default_nettype wire
